// ===== hw/rtl/presence_timed_stop_go_light_defines.svh =====
// Assertion macros for the presence-timed stop/go light.
// Used by the top level; defining NO_ASSERTIONS turns every check into nothing.
`ifndef PRESENCE_TIMED_STOP_GO_LIGHT_DEFINES_SVH
`define PRESENCE_TIMED_STOP_GO_LIGHT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock edge.
`define PTSG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication, sampled on the rising clock edge.
`define PTSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define PTSG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PTSG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/ptsg_pkg.sv =====
// Package for the presence-timed stop/go light: types, register indexes,
// reset values and output phase codes. No dependencies.
`default_nettype none

package ptsg_pkg;

  // Default width of the stored timestamps.
  localparam int unsigned TimeBitsDef = 32;
  // Present samples in a row that start the countdown (1 to 3).
  localparam logic [1:0]  HitsToArm   = 2'd3;
  localparam logic [1:0]  HitRunMax   = 2'd3;

  // Field widths.
  localparam int unsigned TimeInW  = 32;
  localparam int unsigned RangeW   = 14;
  localparam int unsigned TrigW    = 10;
  localparam int unsigned MsW      = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 8;

  // Register reset values.
  localparam logic [TrigW-1:0] TrigReset      = 10'd50;
  localparam logic [MsW-1:0]   CountdownReset = 16'd5000;
  localparam logic [MsW-1:0]   FlashReset     = 16'd500;
  localparam logic [MsW-1:0]   AbortReset     = 16'd1000;
  localparam logic [MsW-1:0]   GreenReset     = 16'd500;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgTrigger   = 3'd0,
    CfgCountdown = 3'd1,
    CfgFlash     = 3'd2,
    CfgAbort     = 3'd3,
    CfgGreen     = 3'd4
  } cfg_reg_e;

  // Light state, one-hot.
  typedef enum logic [2:0] {
    PhWait  = 3'b001,
    PhCount = 3'b010,
    PhGo    = 3'b100
  } phase_e;

  // Phase codes on the output word.
  localparam logic [1:0] PhaseCodeWait  = 2'd0;
  localparam logic [1:0] PhaseCodeCount = 2'd1;
  localparam logic [1:0] PhaseCodeGo    = 2'd2;

  function automatic logic [1:0] phase_code(phase_e p);
    logic [1:0] code;
    unique case (p)
      PhCount: code = PhaseCodeCount;
      PhGo:    code = PhaseCodeGo;
      default: code = PhaseCodeWait;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/presence_timed_stop_go_light.sv =====
// Presence-timed stop/go light: sample register, next-state logic, result register.
// Depends on ptsg_pkg and presence_timed_stop_go_light_defines.svh.
//
// Channel    Direction  Word                              Handshake
// s_axis     in         time_ms, range_fix; no_echo in tuser  tvalid/tready
// m_axis     out        light_phase, green_lamp, red_lamp  tvalid/tready
// cfg        in         register index and data           cfg_we_i, no wait
//
// One word per cycle when the output is taken; an accepted word passes from the sample
// register to the result register, whose contents appear on m_axis.
// The state update and all timer compares sit between those two registers.
// A stall on m_axis holds the result; the sample register still takes one
// more word, then s_axis_tready falls. Reset loads the register defaults
// and puts the light in waiting with empty stages.
`default_nettype none
`include "presence_timed_stop_go_light_defines.svh"

module presence_timed_stop_go_light #(
  parameter int unsigned TIME_BITS = ptsg_pkg::TimeBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Sample stream.
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  // [31:0] time_ms, [45:32] range_fix, [47:46] zero
  input  wire logic [ptsg_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] no_echo
  input  wire logic                           s_axis_tuser,
  // Result stream.
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [1:0] light_phase, [2] green_lamp, [3] red_lamp, [7:4] zero
  output      logic [ptsg_pkg::OutDataW-1:0]  m_axis_tdata,
  // Configuration writes.
  input  wire logic                           cfg_we_i,
  input  wire logic [ptsg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ptsg_pkg::CfgDataW-1:0]  cfg_data_i
);
  import ptsg_pkg::*;

  typedef logic [TIME_BITS-1:0] tstamp_t;

  // Configuration registers.
  logic [TrigW-1:0] trig_q;
  logic [MsW-1:0]   countdown_q, flash_q, abort_q, green_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q      <= TrigReset;
      countdown_q <= CountdownReset;
      flash_q     <= FlashReset;
      abort_q     <= AbortReset;
      green_q     <= GreenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgTrigger:   trig_q      <= cfg_data_i[TrigW-1:0];
        CfgCountdown: countdown_q <= cfg_data_i;
        CfgFlash:     flash_q     <= cfg_data_i;
        CfgAbort:     abort_q     <= cfg_data_i;
        CfgGreen:     green_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake between the two stages.
  logic in_valid_q, out_valid_q;
  logic out_ready, advance;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;

  // Sample register.
  tstamp_t           in_time_q;
  logic [RangeW-1:0] in_range_q;
  logic              in_no_echo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_time_q    <= s_axis_tdata[TIME_BITS-1:0];
      in_range_q   <= s_axis_tdata[TimeInW +: RangeW];
      in_no_echo_q <= s_axis_tuser;
    end
  end

  // Light state.
  phase_e     phase_q, phase_d;
  logic [1:0] hit_run_q, hit_run_d;
  tstamp_t    cd_began_q, cd_began_d;
  tstamp_t    clr_began_q, clr_began_d;
  logic       clr_run_q, clr_run_d;
  tstamp_t    last_tog_q, last_tog_d;
  logic       flash_lvl_q, flash_lvl_d;

  logic       present;
  logic [1:0] hit_inc;
  logic       green_d, red_d;

  // An echo with a distance above zero and below the trigger distance.
  assign present = !in_no_echo_q && (in_range_q != '0) &&
                   (in_range_q < {trig_q, 4'b0000});

  // Next-state logic for the sample in the sample register.
  always_comb begin
    phase_d     = phase_q;
    hit_run_d   = hit_run_q;
    cd_began_d  = cd_began_q;
    clr_began_d = clr_began_q;
    clr_run_d   = clr_run_q;
    last_tog_d  = last_tog_q;
    flash_lvl_d = flash_lvl_q;
    hit_inc     = (hit_run_q < HitRunMax) ? hit_run_q + 2'd1 : hit_run_q;

    unique case (phase_q)
      PhCount: begin
        // Red toggle first.
        if (tstamp_t'(in_time_q - last_tog_q) >= tstamp_t'(flash_q)) begin
          flash_lvl_d = !flash_lvl_q;
          last_tog_d  = in_time_q;
        end
        // Clear timer.
        if (present) begin
          clr_run_d = 1'b0;
        end else if (!clr_run_q) begin
          clr_run_d   = 1'b1;
          clr_began_d = in_time_q;
        end
        // Abort has priority over the expiry to green.
        if (clr_run_d && (tstamp_t'(in_time_q - clr_began_d) >= tstamp_t'(abort_q))) begin
          phase_d   = PhWait;
          clr_run_d = 1'b0;
        end else if (tstamp_t'(in_time_q - cd_began_q) >= tstamp_t'(countdown_q)) begin
          phase_d   = PhGo;
          clr_run_d = 1'b0;
        end
      end
      PhGo: begin
        if (present) begin
          clr_run_d = 1'b0;
        end else if (!clr_run_q) begin
          clr_run_d   = 1'b1;
          clr_began_d = in_time_q;
        end
        if (clr_run_d && (tstamp_t'(in_time_q - clr_began_d) >= tstamp_t'(green_q))) begin
          phase_d   = PhWait;
          clr_run_d = 1'b0;
        end
      end
      default: begin
        // Waiting: count present samples in a row.
        phase_d = PhWait;
        if (present) begin
          hit_run_d = hit_inc;
          if (hit_inc >= HitsToArm) begin
            phase_d     = PhCount;
            flash_lvl_d = 1'b0;
            last_tog_d  = in_time_q;
            cd_began_d  = in_time_q;
            clr_run_d   = 1'b0;
            hit_run_d   = 2'd0;
          end
        end else begin
          hit_run_d = 2'd0;
        end
      end
    endcase

    // Lamp levels after this sample.
    green_d = (phase_d == PhGo);
    red_d   = (phase_d == PhCount) ? flash_lvl_d : (phase_d != PhGo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhWait;
      hit_run_q   <= 2'd0;
      cd_began_q  <= '0;
      clr_began_q <= '0;
      clr_run_q   <= 1'b0;
      last_tog_q  <= '0;
      flash_lvl_q <= 1'b0;
    end else if (advance) begin
      phase_q     <= phase_d;
      hit_run_q   <= hit_run_d;
      cd_began_q  <= cd_began_d;
      clr_began_q <= clr_began_d;
      clr_run_q   <= clr_run_d;
      last_tog_q  <= last_tog_d;
      flash_lvl_q <= flash_lvl_d;
    end
  end

  // Result register.
  logic [OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {4'b0000, red_d, green_d, phase_code(phase_d)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks on the design's own state and flow control.
  `PTSG_ASSERT_IMPL(a_lamps_exclusive, clk_i, rst_ni, m_axis_tvalid,
                    !(m_axis_tdata[2] && m_axis_tdata[3]))
  `PTSG_ASSERT_IMPL(a_hit_run_bound, clk_i, rst_ni, 1'b1, hit_run_q < HitsToArm)
  `PTSG_ASSERT_IMPL(a_hit_run_waiting, clk_i, rst_ni, hit_run_q != 2'd0, phase_q == PhWait)
  `PTSG_ASSERT_IMPL(a_full_blocks_input, clk_i, rst_ni, in_valid_q && !out_ready,
                    !s_axis_tready)
  `PTSG_ASSERT_NEXT(a_state_held, clk_i, rst_ni, !advance, $stable(phase_q))

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for presence_timed_stop_go_light: sends sensor sample words,
// predicts each light word in order and compares every result word field by field.
// Depends on ptsg_pkg and the presence_timed_stop_go_light top level.
module tb_top;
  import ptsg_pkg::*;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned ItemsPerSetting = 105;
  localparam int unsigned ShownMismatches = 10;
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  // One result word, laid out as on m_axis_tdata[3:0].
  typedef struct packed {
    logic       red;
    logic       green;
    logic [1:0] phase;
  } light_word_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  presence_timed_stop_go_light u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Shadow copy of the configuration registers.
  logic [TrigW-1:0] trig_cm;
  logic [MsW-1:0]   countdown_len;
  logic [MsW-1:0]   flash_period;
  logic [MsW-1:0]   abort_len;
  logic [MsW-1:0]   green_len;

  // Predicted light state.
  logic [1:0]  lt_phase;
  logic [1:0]  lt_hits;
  logic [31:0] lt_cd_start;
  logic [31:0] lt_clr_start;
  logic [31:0] lt_toggle_at;
  logic        lt_clr_on;
  logic        lt_flash;

  light_word_t expected_lights[$];
  logic [31:0] sample_time;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned settings_used = 1;
  int unsigned idle_cycles   = 0;
  int unsigned rx_mode       = 0;
  int unsigned rx_mode_left  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Light predictor.

  task automatic reset_predictor();
    trig_cm       = TrigReset;
    countdown_len = CountdownReset;
    flash_period  = FlashReset;
    abort_len     = AbortReset;
    green_len     = GreenReset;
    lt_phase      = PhaseCodeWait;
    lt_hits       = '0;
    lt_cd_start   = '0;
    lt_clr_start  = '0;
    lt_toggle_at  = '0;
    lt_clr_on     = 1'b0;
    lt_flash      = 1'b0;
  endtask

  // Time differences wrap at 32 bits.
  function automatic logic [31:0] ms_since(logic [31:0] now, logic [31:0] then);
    return now - then;
  endfunction

  // The clear timer starts on the first clear sample and stops on any presence.
  task automatic track_clear(input logic present, input logic [31:0] now);
    if (present) begin
      lt_clr_on = 1'b0;
    end else if (!lt_clr_on) begin
      lt_clr_on    = 1'b1;
      lt_clr_start = now;
    end
  endtask

  task automatic predict_light(input logic [31:0] now, input logic [13:0] range_fix,
                               input logic no_echo);
    logic        present;
    light_word_t w;
    present = !no_echo && (range_fix != '0) && (range_fix < {trig_cm, 4'b0000});
    case (lt_phase)
      PhaseCodeCount: begin
        // Flash toggle first, then the clear timer, then abort ahead of expiry.
        if (ms_since(now, lt_toggle_at) >= {16'd0, flash_period}) begin
          lt_flash     = !lt_flash;
          lt_toggle_at = now;
        end
        track_clear(present, now);
        if (lt_clr_on && ms_since(now, lt_clr_start) >= {16'd0, abort_len}) begin
          lt_phase  = PhaseCodeWait;
          lt_clr_on = 1'b0;
        end else if (ms_since(now, lt_cd_start) >= {16'd0, countdown_len}) begin
          lt_phase  = PhaseCodeGo;
          lt_clr_on = 1'b0;
        end
      end
      PhaseCodeGo: begin
        track_clear(present, now);
        if (lt_clr_on && ms_since(now, lt_clr_start) >= {16'd0, green_len}) begin
          lt_phase  = PhaseCodeWait;
          lt_clr_on = 1'b0;
        end
      end
      default: begin
        lt_phase = PhaseCodeWait;
        if (present) begin
          if (lt_hits < HitRunMax) lt_hits = lt_hits + 2'd1;
          if (lt_hits >= HitsToArm) begin
            lt_phase     = PhaseCodeCount;
            lt_flash     = 1'b0;
            lt_toggle_at = now;
            lt_cd_start  = now;
            lt_clr_on    = 1'b0;
            lt_hits      = '0;
          end
        end else begin
          lt_hits = '0;
        end
      end
    endcase
    w.phase = lt_phase;
    w.green = (lt_phase == PhaseCodeGo);
    if (lt_phase == PhaseCodeCount) begin
      w.red = lt_flash;
    end else begin
      w.red = (lt_phase != PhaseCodeGo);
    end
    expected_lights.push_back(w);
  endtask

  // Stimulus helpers.

  // Offers one sample word and waits until it is taken; valid stays high.
  task automatic send_sample(input logic [31:0] now, input logic [13:0] range_fix,
                             input logic no_echo);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, range_fix, now};
    s_axis_tuser  <= no_echo;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_light(now, range_fix, no_echo);
    items_sent++;
  endtask

  // Gap between bursts, with junk on the data lines while valid is low.
  task automatic idle_sender(input int unsigned cycles);
    if (cycles != 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {16'($urandom()), 32'($urandom())};
      s_axis_tuser  <= 1'($urandom());
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Holds the sender until every predicted word has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_lights.size() != 0) @(posedge clk_i);
  endtask

  task automatic drive_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Writes all registers, then an unused index that must be ignored.
  task automatic set_light_config(input logic [TrigW-1:0] trig, input logic [MsW-1:0] cd,
                                  input logic [MsW-1:0] fl, input logic [MsW-1:0] ab,
                                  input logic [MsW-1:0] gr);
    // Upper bits above the trigger field must be dropped by the block.
    drive_cfg(CfgTrigger, {6'($urandom()), trig});
    drive_cfg(CfgCountdown, cd);
    drive_cfg(CfgFlash, fl);
    drive_cfg(CfgAbort, ab);
    drive_cfg(CfgGreen, gr);
    drive_cfg(CfgUnused, 16'($urandom()));
    cfg_we_i      <= 1'b0;
    trig_cm       = trig;
    countdown_len = cd;
    flash_period  = fl;
    abort_len     = ab;
    green_len     = gr;
    settings_used++;
  endtask

  // Tests.

  // Reset settings: presence edges, flashing, abort, go and the clear
  // timeout in green, with the countdown crossing the timestamp wrap.
  task automatic test_default_light_cycle();
    logic [31:0] t0;
    t0 = 32'hFFFF_F000;
    send_sample(t0,         14'd0,     1'b0);
    send_sample(t0 + 10,    14'h3FFF,  1'b0);
    send_sample(t0 + 20,    14'd799,   1'b1);
    send_sample(t0 + 30,    14'd799,   1'b0);
    send_sample(t0 + 40,    14'd800,   1'b0);
    send_sample(t0 + 50,    14'd1,     1'b0);
    send_sample(t0 + 60,    14'd799,   1'b0);
    send_sample(t0 + 70,    14'd400,   1'b0);
    send_sample(t0 + 570,   14'd400,   1'b0);
    send_sample(t0 + 900,   14'd0,     1'b1);
    send_sample(t0 + 1899,  14'h3FFF,  1'b0);
    send_sample(t0 + 1900,  14'd900,   1'b0);
    send_sample(t0 + 2000,  14'd300,   1'b0);
    send_sample(t0 + 2010,  14'd300,   1'b0);
    send_sample(t0 + 2020,  14'd300,   1'b0);
    send_sample(t0 + 7019,  14'd300,   1'b0);
    send_sample(t0 + 7020,  14'd300,   1'b0);
    send_sample(t0 + 7100,  14'd0,     1'b1);
    send_sample(t0 + 7599,  14'd0,     1'b1);
    send_sample(t0 + 7600,  14'd0,     1'b1);
    send_sample(32'hFFFF_FFFF, 14'h3FFF, 1'b1);
  endtask

  // Zero trigger never sees presence; zero timeouts and a zero flash
  // interval act on the first sample that allows them.
  task automatic test_zero_thresholds();
    drain_results();
    set_light_config(10'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(32'd100, 14'd1, 1'b0);
    send_sample(32'd101, 14'd1, 1'b0);
    send_sample(32'd102, 14'd1, 1'b0);
    drain_results();
    set_light_config(10'h3FF, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(32'd200, 14'd16367, 1'b0);
    send_sample(32'd200, 14'd16368, 1'b0);
    send_sample(32'd201, 14'd16367, 1'b0);
    send_sample(32'd202, 14'd1,     1'b0);
    send_sample(32'd203, 14'd5000,  1'b0);
    send_sample(32'd203, 14'd5000,  1'b0);
    send_sample(32'd204, 14'd0,     1'b1);
    send_sample(32'd205, 14'd9,     1'b0);
    send_sample(32'd206, 14'd9,     1'b0);
    send_sample(32'd207, 14'd9,     1'b0);
    send_sample(32'd207, 14'd0,     1'b1);
  endtask

  // Bursts of samples from an object that comes and goes, with noise,
  // time steps scaled to the current timeouts and occasional wrap jumps.
  task automatic run_random_traffic(input int unsigned n_items);
    int unsigned span;
    int unsigned burst_left;
    int unsigned thr;
    logic        near;
    logic [13:0] range_fix;
    logic        no_echo;
    span = 32'(countdown_len);
    if (32'(abort_len) > span) span = 32'(abort_len);
    if (32'(green_len) > span) span = 32'(green_len);
    span = span / 3 + 2;
    thr = 32'({trig_cm, 4'b0000});
    burst_left = 0;
    near = 1'b0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        idle_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5));
      end
      burst_left--;
      if (i == n_items / 2) drain_results();
      case ($urandom_range(0, 15))
        0:       sample_time = sample_time;
        1:       sample_time = sample_time + $urandom();
        2, 3:    sample_time = sample_time + $urandom_range(1, 8);
        default: sample_time = sample_time + $urandom_range(1, span);
      endcase
      if ($urandom_range(0, 7) == 0) near = !near;
      if ($urandom_range(0, 9) == 0) begin
        range_fix = 14'($urandom());
        no_echo   = 1'($urandom());
      end else if (near) begin
        range_fix = (thr > 1) ? 14'($urandom_range(1, thr - 1)) : 14'd1;
        no_echo   = ($urandom_range(0, 19) == 0);
      end else begin
        no_echo = 1'b0;
        case ($urandom_range(0, 2))
          0: begin
            range_fix = 14'($urandom());
            no_echo   = 1'b1;
          end
          1:       range_fix = '0;
          default: range_fix = 14'($urandom_range(thr, 16383));
        endcase
      end
      send_sample(sample_time, range_fix, no_echo);
    end
  endtask

  // Extreme settings first, then random ones.
  task automatic test_random_settings();
    sample_time = $urandom();
    for (int s = 0; s < 5; s++) begin
      drain_results();
      case (s)
        0: set_light_config(10'h3FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: set_light_config(10'd1, 16'd0, 16'd1, 16'd0, 16'd0);
        default: set_light_config(10'($urandom_range(5, 300)), 16'($urandom_range(0, 3000)),
                                  16'($urandom_range(1, 400)), 16'($urandom_range(0, 1500)),
                                  16'($urandom_range(0, 1500)));
      endcase
      run_random_traffic(ItemsPerSetting);
    end
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk_i) begin : check_lights
    light_word_t want;
    light_word_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[3:0];
        results_seen++;
        if (expected_lights.size() == 0) begin
          mismatches++;
          if (mismatches <= ShownMismatches)
            $display("unexpected result word %h at %0t", m_axis_tdata, $realtime);
        end else begin
          want = expected_lights.pop_front();
          if (got.phase != want.phase || got.green != want.green || got.red != want.red) begin
            mismatches++;
            if (mismatches <= ShownMismatches)
              $display(
                "word %0d: expected phase %0d green %b red %b, got phase %0d green %b red %b",
                results_seen, want.phase, want.green, want.red,
                got.phase, got.green, got.red);
          end
        end
      end
      // The receiver switches between always ready, random and mostly stalled.
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(20, 80);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom());
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("watchdog: no word accepted for %0d cycles", IdleLimit);
      $display("FAIL presence_timed_stop_go_light");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_predictor();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_light_cycle();
    test_zero_thresholds();
    test_random_settings();
    drain_results();
    repeat (4) @(posedge clk_i);
    if (expected_lights.size() != 0) begin
      $display("%0d light words never arrived", expected_lights.size());
      mismatches += expected_lights.size();
    end
    $display("Sent %0d sensor words under %0d register settings, checked %0d light words.",
             items_sent, settings_used, results_seen);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("PASS presence_timed_stop_go_light");
    end else begin
      $display("FAIL presence_timed_stop_go_light");
    end
    $finish;
  end

endmodule
